// ===== rtl/core/ksxhm_pkg.sv =====
package ksxhm_pkg;

   localparam int unsigned HASH_W  = 32;
   localparam int unsigned DIV_W   = 31;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LEN_W   = 13;
   localparam int unsigned ASM_W   = 24;
   localparam int unsigned QDEPTH  = 2;
   localparam int unsigned QPTR_W  = 1;
   localparam int unsigned QCNT_W  = 2;
   localparam int unsigned STEP_W  = 5;

   // position saturates here
   localparam logic [LEN_W-1:0] POS_MAX = 13'd8191;

   // one finished key waiting for reduction
   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [DIV_W-1:0]  divisor;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/core/key_shift_xor_hash_mod.sv =====
// Path: an accepted final (or empty-key) item passes the front register and the job
//   queue; a zero divisor skips the divider, a nonzero one runs the 32-step divider.
// Throughput: one key byte per cycle unless stalled; a two-entry job queue lets the
//   byte front run ahead of the divider, which takes a job only when it is idle.
// Reset: synchronous, active high; clears hash state, queue, divider and divisor.
module key_shift_xor_hash_mod #(
   parameter int unsigned MAX_KEY_BYTES = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   // key bytes in
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ksxhm_pkg::BYTE_W-1:0]    req_key_byte,
   input  logic [ksxhm_pkg::LEN_W-1:0]     req_key_length,
   input  logic                            req_final_byte,
   // finished hashes out
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ksxhm_pkg::HASH_W-1:0]    rsp_hash_value,
   // divisor register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ksxhm_pkg::DIV_W-1:0]     csr_divisor
);

   logic [ksxhm_pkg::DIV_W-1:0]  divisor_ff, divisor_in;
   logic                         push;
   logic                         pop;
   ksxhm_pkg::job_type           push_job;
   ksxhm_pkg::job_type           pop_job;
   ksxhm_pkg::q_status_type      q_status;

   // register always accepts a write
   assign csr_ready  = 1'b1;
   assign divisor_in = (csr_valid && csr_ready) ? csr_divisor : divisor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= '0;
      end else begin
         divisor_ff <= divisor_in;
      end
   end

   // hold new items while the queue cannot take another job; a job already on its
   // way out of the front register counts against the queue's free space
   assign req_stall = q_status.full || (push && !q_status.empty);

   // byte front: fold each item into the running hash, emit a job on the key's end
   ksxhm_front #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_byte   (req_key_byte),
      .req_key_length (req_key_length),
      .req_final_byte (req_final_byte),
      .divisor        (divisor_ff),
      .push           (push),
      .push_job       (push_job)
   );

   // decouple the byte front from the divider
   ksxhm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   // back end: reduce modulo divisor and drive the result register
   ksxhm_div u_div (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .pop_job        (pop_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

// ===== rtl/core/ksxhm_front.sv =====
module ksxhm_front #(
   parameter int unsigned MAX_KEY_BYTES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [ksxhm_pkg::BYTE_W-1:0]      req_key_byte,
   input  logic [ksxhm_pkg::LEN_W-1:0]       req_key_length,
   input  logic                              req_final_byte,
   input  logic [ksxhm_pkg::DIV_W-1:0]       divisor,
   output logic                              push,
   output ksxhm_pkg::job_type                push_job
);

   logic [ksxhm_pkg::HASH_W-1:0] acc_ff, acc_in;
   logic [ksxhm_pkg::LEN_W-1:0]  pos_ff, pos_in;
   logic [ksxhm_pkg::ASM_W-1:0]  asm_ff, asm_in;
   logic                         push_ff, push_in;
   ksxhm_pkg::job_type           job_ff, job_in;

   logic [15:0]                  len_c;
   logic [1:0]                   small_c;
   logic [1:0]                   lane_c;
   logic [ksxhm_pkg::HASH_W-1:0] acc_new;
   logic                         accepted;

   always_comb begin
      accepted = req_valid && !req_stall;
      len_c    = ({3'b000, req_key_length} > 16'(MAX_KEY_BYTES)) ?
                 16'(MAX_KEY_BYTES) : {3'b000, req_key_length};
      small_c  = len_c[1:0];
      lane_c   = pos_ff[1:0] - small_c;
      acc_new  = acc_ff;
      acc_in   = acc_ff;
      pos_in   = pos_ff;
      asm_in   = asm_ff;
      push_in  = 1'b0;
      job_in   = job_ff;
      if (accepted) begin
         if (req_key_length == '0) begin
            acc_in         = '0;
            pos_in         = '0;
            asm_in         = '0;
            push_in        = 1'b1;
            job_in.hash    = '0;
            job_in.divisor = divisor;
         end else begin
            if ({3'b000, pos_ff} < len_c) begin
               if ({14'd0, pos_ff[1:0]} < {14'd0, small_c} && pos_ff < 13'd4) begin
                  acc_new = {acc_ff[23:0], req_key_byte};
               end else if (lane_c == 2'd3) begin
                  acc_new = {acc_ff[30:0], 1'b0} ^ {req_key_byte, asm_ff};
                  asm_in  = '0;
               end else begin
                  asm_in = asm_ff | (24'(req_key_byte) << {lane_c, 3'b000});
               end
            end
            acc_in = acc_new;
            if (pos_ff < ksxhm_pkg::POS_MAX) begin
               pos_in = pos_ff + 13'd1;
            end
            if (req_final_byte) begin
               acc_in         = '0;
               pos_in         = '0;
               asm_in         = '0;
               push_in        = 1'b1;
               job_in.hash    = acc_new;
               job_in.divisor = divisor;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pos_ff  <= '0;
         asm_ff  <= '0;
         push_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         pos_ff  <= pos_in;
         asm_ff  <= asm_in;
         push_ff <= push_in;
      end
      job_ff <= job_in;
   end

   assign push     = push_ff;
   assign push_job = job_ff;

endmodule

// ===== rtl/core/ksxhm_queue.sv =====
module ksxhm_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ksxhm_pkg::job_type       push_job,
   input  logic                     pop,
   output ksxhm_pkg::job_type       pop_job,
   output ksxhm_pkg::q_status_type  status
);

   localparam int unsigned QCNT_W = ksxhm_pkg::QCNT_W;

   ksxhm_pkg::job_type                mem_ff [ksxhm_pkg::QDEPTH];
   logic [ksxhm_pkg::QPTR_W-1:0]      wr_ff, wr_in;
   logic [ksxhm_pkg::QPTR_W-1:0]      rd_ff, rd_in;
   logic [ksxhm_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   assign pop_job      = mem_ff[rd_ff];
   assign status.full  = (cnt_ff == QCNT_W'(ksxhm_pkg::QDEPTH));
   assign status.empty = (cnt_ff == '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue pop while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(ksxhm_pkg::QDEPTH))
      else $error("queue count out of range");

endmodule

// ===== rtl/core/ksxhm_div.sv =====
module ksxhm_div (
   input  logic                            clock,
   input  logic                            reset,
   input  ksxhm_pkg::q_status_type         q_status,
   input  ksxhm_pkg::job_type              pop_job,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ksxhm_pkg::HASH_W-1:0]    rsp_hash_value
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_HOLD = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [ksxhm_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [ksxhm_pkg::HASH_W-1:0]    dvd_ff, dvd_in;
   logic [ksxhm_pkg::DIV_W-1:0]     rem_ff, rem_in;
   logic [ksxhm_pkg::DIV_W-1:0]     div_ff, div_in;
   logic [ksxhm_pkg::HASH_W-1:0]    res_ff, res_in;
   logic                            out_valid_ff, out_valid_in;
   logic [ksxhm_pkg::HASH_W-1:0]    out_ff, out_in;

   logic [ksxhm_pkg::HASH_W-1:0]    trial;
   logic [ksxhm_pkg::DIV_W-1:0]     rem_next;
   logic                            out_free;

   always_comb begin
      trial    = {rem_ff, dvd_ff[ksxhm_pkg::HASH_W-1]};
      rem_next = (trial >= {1'b0, div_ff}) ?
                 ksxhm_pkg::DIV_W'(trial - {1'b0, div_ff}) : trial[ksxhm_pkg::DIV_W-1:0];
      out_free = !out_valid_ff || !rsp_stall;

      state_in     = state_ff;
      step_in      = step_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      pop          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               div_in = pop_job.divisor;
               if (pop_job.divisor == '0) begin
                  res_in   = pop_job.hash;
                  state_in = S_HOLD;
               end else begin
                  dvd_in   = pop_job.hash;
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            // one quotient bit per cycle, restoring
            rem_in  = rem_next;
            dvd_in  = {dvd_ff[ksxhm_pkg::HASH_W-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == '1) begin
               res_in   = {1'b0, rem_next};
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hash_value = out_ff;

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> div_ff != '0)
      else $error("divider running with zero divisor");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> rem_ff < div_ff)
      else $error("partial remainder not below divisor");

   a_res_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD && div_ff != '0) |-> res_ff < {1'b0, div_ff})
      else $error("reduced hash not below divisor");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == S_IDLE)
      else $error("job taken while divider busy");

endmodule

// ===== test/key_shift_xor_hash_mod_tb.sv =====
module key_shift_xor_hash_mod_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned       CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned       SETTLE_CYCLES = 48;     // margin for the divider path to drain
   localparam int unsigned       RANDOM_ITEMS  = 410;
   localparam logic [12:0]       MAX_KEY_LEN   = 13'd4096;
   localparam logic [30:0]       DIVISOR_MAX   = 31'h7FFF_FFFF;

   logic                                 clock;
   logic                                 reset          = 1'b1;
   logic                                 req_valid      = 1'b0;
   logic                                 req_stall;
   logic [ksxhm_pkg::BYTE_W-1:0]         req_key_byte   = '0;
   logic [ksxhm_pkg::LEN_W-1:0]          req_key_length = '0;
   logic                                 req_final_byte = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall      = 1'b0;
   logic [ksxhm_pkg::HASH_W-1:0]         rsp_hash_value;
   logic                                 csr_valid      = 1'b0;
   logic                                 csr_ready;
   logic [ksxhm_pkg::DIV_W-1:0]          csr_divisor    = '0;

   // Shadow copy of the hash state and the divisor register.
   logic [ksxhm_pkg::HASH_W-1:0]         hash_acc;
   logic [ksxhm_pkg::LEN_W-1:0]          key_pos;
   logic [ksxhm_pkg::ASM_W-1:0]          word_bytes;
   logic [ksxhm_pkg::DIV_W-1:0]          divisor_setting;

   // Hashes predicted but not yet seen on the result port, oldest first.
   logic [ksxhm_pkg::HASH_W-1:0]         pending_hashes[$];
   logic [ksxhm_pkg::HASH_W-1:0]         wanted_hash;

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned items_sent     = 0;
   int unsigned burst_left     = 0;    // items still to send back to back
   int unsigned rsp_hold       = 0;    // cycles of stall still to apply
   int unsigned rsp_calm       = 0;    // results still to take without stalling

   key_shift_xor_hash_mod u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_byte   (req_key_byte),
      .req_key_length (req_key_length),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_divisor    (csr_divisor)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: give up on a hang and call the run failed.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Hash predictor
   // ------------------------------------------------------------------

   task automatic clear_key_state();
      hash_acc   = '0;
      key_pos    = '0;
      word_bytes = '0;
   endtask

   // Advance the shadow state by one accepted item and queue the hash it yields.
   task automatic fold_key_byte(input logic [7:0] kbyte, input logic [12:0] klen,
                                input logic fin);
      logic [12:0] eff_len;
      logic [1:0]  lane;
      logic [31:0] hash;
      // An empty key ignores its byte and final flag, answers zero and clears the key.
      if (klen == '0) begin
         clear_key_state();
         pending_hashes.push_back('0);
         return;
      end
      // Clamp an overlong length before taking the head size from it.
      eff_len = (klen > MAX_KEY_LEN) ? MAX_KEY_LEN : klen;
      if (key_pos < eff_len) begin
         if (key_pos < 13'(eff_len[1:0])) begin
            // Head bytes fold in base 256.
            hash_acc = {hash_acc[23:0], kbyte};
         end else begin
            // Body bytes gather into a little-endian word, earliest byte lowest.
            lane = key_pos[1:0] - eff_len[1:0];
            if (lane != 2'd3) begin
               word_bytes = word_bytes | (24'(kbyte) << (8 * lane));
            end else begin
               hash_acc   = {hash_acc[30:0], 1'b0} ^ {kbyte, word_bytes};
               word_bytes = '0;
            end
         end
      end
      // Saturate the position instead of wrapping.
      if (key_pos != ksxhm_pkg::POS_MAX) key_pos++;
      if (fin) begin
         // Any half-built word is dropped on an early final.
         hash = (divisor_setting == '0) ? hash_acc : hash_acc % {1'b0, divisor_setting};
         pending_hashes.push_back(hash);
         clear_key_state();
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: stall at random, check every accepted hash in order
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_hashes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected hash %h with nothing pending", rsp_hash_value);
            end else begin
               wanted_hash = pending_hashes.pop_front();
               if (rsp_hash_value !== wanted_hash) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("hash_value mismatch: expected %h, got %h",
                              wanted_hash, rsp_hash_value);
               end
            end
            // Draw the stall ahead of the next hash; now and then take a calm run.
            if (rsp_calm > 0) begin
               rsp_calm--;
               rsp_hold = 0;
            end else if ($urandom_range(0, 9) == 0) begin
               rsp_calm = $urandom_range(10, 30);
               rsp_hold = 0;
            end else begin
               rsp_hold = $urandom_range(0, 10);
            end
         end
         // Count the stall down whether or not a hash is on offer, so gaps land anywhere.
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side helpers
   // ------------------------------------------------------------------

   // Offer one item after a random gap, hold it until taken, then predict.
   task automatic send_item(input logic [7:0] kbyte, input logic [12:0] klen,
                            input logic fin);
      int unsigned gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = $urandom_range(0, 10);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_key_byte   <= kbyte;
      req_key_length <= klen;
      req_final_byte <= fin;
      do @(posedge clock); while (req_stall);
      fold_key_byte(kbyte, klen, fin);
      items_sent++;
   endtask

   // Send count random bytes under one length field; mark the last one final if asked.
   task automatic send_key(input logic [12:0] klen, input int unsigned count,
                           input bit mark_final);
      if (burst_left == 0 && $urandom_range(0, 7) == 0)
         burst_left = $urandom_range(10, 40);
      for (int unsigned i = 0; i < count; i++)
         send_item(8'($urandom), klen, mark_final && (i == count - 1));
   endtask

   // Drop valid, let every pending hash come home, then let the divider settle.
   task automatic drain_hashes();
      req_valid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the divisor only once the block is idle.
   task automatic set_divisor(input logic [30:0] value);
      drain_hashes();
      csr_valid   <= 1'b1;
      csr_divisor <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      divisor_setting = value;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Empty keys answer zero whatever the byte and final flag say.
   task automatic test_empty_keys();
      send_item(8'hA5, 13'd0, 1'b0);
      send_item(8'hFF, 13'd0, 1'b1);
      send_item(8'h00, 13'd0, 1'b1);
   endtask

   // Short keys at byte extremes: head-only, word-only and mixed layouts.
   task automatic test_short_keys();
      send_item(8'hFF, 13'd1, 1'b1);
      send_item(8'h00, 13'd4, 1'b0);
      send_item(8'hFF, 13'd4, 1'b0);
      send_item(8'h80, 13'd4, 1'b0);
      send_item(8'h01, 13'd4, 1'b1);
      for (int i = 0; i < 7; i++)
         send_item(8'hFF, 13'd7, i == 6);
   endtask

   task automatic test_special_cases();
      // Overlong length: 4097 clamps to 4096, so no head bytes; final comes early.
      send_item(8'h12, 13'd4097, 1'b0);
      send_item(8'h34, 13'd4097, 1'b1);
      send_item(8'hC3, 13'h1FFF, 1'b1);
      // Bytes beyond the length are not folded.
      send_key(13'd2, 5, 1'b1);
      // Early final drops the partial word.
      send_key(13'd7, 5, 1'b1);
      // Length changes in the middle of a key.
      send_key(13'd6, 2, 1'b0);
      send_key(13'd3, 2, 1'b1);
      // No final mark: state runs on into the next key, then an empty key clears it.
      send_key(13'd3, 2, 1'b0);
      send_key(13'd5, 3, 1'b1);
      send_key(13'd4, 2, 1'b0);
      send_item(8'h5A, 13'd0, 1'b0);
   endtask

   // Smallest and largest nonzero divisors, then back to the raw hash.
   task automatic test_divisor_extremes();
      set_divisor(31'd1);
      send_key(13'd5, 5, 1'b1);
      set_divisor(DIVISOR_MAX);
      send_key(13'd8, 8, 1'b1);
      send_item(8'hFF, 13'd0, 1'b1);
      send_key(13'd3, 3, 1'b1);
      set_divisor(31'd0);
      send_key(13'd4, 4, 1'b1);
   endtask

   task automatic test_long_keys();
      // A long key with many whole words, sent back to back.
      set_divisor(31'd65521);
      burst_left = 128;
      send_key(13'd128, 128, 1'b1);
   endtask

   task automatic test_random_keys();
      int unsigned start_count;
      int unsigned last_csr;
      int unsigned choice;
      int unsigned klen;
      int unsigned nbytes;
      start_count = items_sent;
      last_csr    = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         // Move to a new divisor every hundred items or so.
         if (items_sent - last_csr >= 100) begin
            case ($urandom_range(0, 4))
               0:       set_divisor(31'd0);
               1:       set_divisor(31'd1);
               2:       set_divisor(DIVISOR_MAX);
               3:       set_divisor(31'($urandom_range(2, 1000)));
               default: set_divisor(31'($urandom));
            endcase
            last_csr = items_sent;
         end
         klen   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
         choice = $urandom_range(0, 99);
         if (choice < 70) begin
            // Well-formed key.
            send_key(13'(klen), klen, 1'b1);
         end else if (choice < 75) begin
            send_item(8'($urandom), 13'd0, 1'($urandom));
         end else if (choice < 80) begin
            // Overlong length field, short actual key.
            send_key(13'($urandom_range(4097, 8191)), $urandom_range(1, 8), 1'b1);
         end else if (choice < 85) begin
            nbytes = (klen > 1) ? $urandom_range(1, klen - 1) : 1;
            send_key(13'(klen), nbytes, 1'b1);
         end else if (choice < 90) begin
            send_key(13'(klen), klen + $urandom_range(1, 6), 1'b1);
         end else if (choice < 95) begin
            nbytes = $urandom_range(1, klen);
            send_key(13'(klen), nbytes, 1'b0);
            klen = $urandom_range(1, 12);
            send_key(13'(klen), $urandom_range(1, klen), 1'b1);
         end else begin
            // Unterminated fragment; the next key carries its state on.
            send_key(13'(klen), $urandom_range(1, klen), 1'b0);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin
      divisor_setting = '0;
      clear_key_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_keys();
      test_short_keys();
      test_special_cases();
      test_divisor_extremes();
      test_long_keys();
      test_random_keys();

      // Close any open key so no state is left dangling, then drain.
      send_item(8'h00, 13'd0, 1'b1);
      drain_hashes();

      if (mismatch_count == 0 && pending_hashes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
